>>> rtl/clcd_pkg.sv
// Shared types, codes and constant tables for the character LCD nibble write sequencer.
package clcd_pkg;

  // Request codes carried on the input tuser.
  localparam logic [1:0] FUNC_CMD  = 2'd0;
  localparam logic [1:0] FUNC_DATA = 2'd1;
  localparam logic [1:0] FUNC_INIT = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SETUP_DELAY = 1'b0;
  localparam logic CFG_ENABLE_HIGH = 1'b1;

  localparam logic [15:0] SETUP_DELAY_RST = 16'd10000;
  localparam logic [15:0] ENABLE_HIGH_RST = 16'd10000;

  // Pin states within one byte write.
  localparam logic [2:0] STEP_SETUP = 3'd0;
  localparam logic [2:0] STEP_HI_EN = 3'd1;
  localparam logic [2:0] STEP_HI_LO = 3'd2;
  localparam logic [2:0] STEP_LO_EN = 3'd3;
  localparam logic [2:0] STEP_LO_LO = 3'd4;

  localparam int unsigned NumInitBytes = 9;
  localparam logic [3:0] LAST_INIT_IDX = 4'(NumInitBytes - 1);

  // Controller to datapath command group.
  typedef struct packed {
    logic       load;      // latch a new request
    logic       is_init;   // request is the initialization sequence
    logic       emit;      // present one pin state on the output
    logic [2:0] step;      // pin state within the byte
    logic [3:0] byte_idx;  // byte within the initialization sequence
    logic       last;      // this pin state ends the request
  } clcd_cmd_t;

  function automatic logic [7:0] init_cmd(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h03;
      4'd1:    c = 8'h03;
      4'd2:    c = 8'h03;
      4'd3:    c = 8'h02;
      4'd4:    c = 8'h02;
      4'd5:    c = 8'h08;
      4'd6:    c = 8'h0C;
      4'd7:    c = 8'h01;
      4'd8:    c = 8'h06;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] init_wait(input logic [3:0] idx);
    logic [15:0] w;
    case (idx)
      4'd0:    w = 16'd10000;
      4'd1:    w = 16'd200;
      4'd2:    w = 16'd10000;
      4'd3:    w = 16'd100;
      4'd4:    w = 16'd100;
      4'd5:    w = 16'd100;
      4'd6:    w = 16'd100;
      4'd7:    w = 16'd100;
      4'd8:    w = 16'd10000;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/clcd_ctrl.sv
// Sequencing state machine that walks the pin states of a request.
module clcd_ctrl import clcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_func_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  output clcd_cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic       state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [3:0] idx_q, idx_d;
  logic       init_q, init_d;
  logic       accept;
  logic       byte_done;
  logic       req_done;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign byte_done  = (step_q == STEP_LO_LO);
  assign req_done   = byte_done && (!init_q || idx_q == LAST_INIT_IDX);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    init_d  = init_q;
    cmd_o   = '0;
    cmd_o.step     = step_q;
    cmd_o.byte_idx = idx_q;
    cmd_o.is_init  = init_q;
    cmd_o.last     = req_done;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_func_i != FUNC_NONE) begin
          cmd_o.load    = 1'b1;
          cmd_o.is_init = (in_func_i == FUNC_INIT);
          init_d  = (in_func_i == FUNC_INIT);
          step_d  = STEP_SETUP;
          idx_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          if (req_done) begin
            state_d = S_IDLE;
          end else if (byte_done) begin
            step_d = STEP_SETUP;
            idx_d  = idx_q + 4'd1;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= STEP_SETUP;
      idx_q   <= '0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      init_q  <= init_d;
    end
  end

endmodule

>>> rtl/clcd_dp.sv
// Datapath: timing registers, pin level state, pin state build and output register.
module clcd_dp import clcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [1:0]  in_func_i,
  input  logic [7:0]  in_value_i,
  input  clcd_cmd_t   cmd_i,
  output logic        out_free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_rs_o,
  output logic        out_en_o,
  output logic [3:0]  out_nibble_o,
  output logic [15:0] out_hold_o,
  output logic        out_last_o
);

  logic [15:0] setup_delay_q, enable_high_q;
  logic        rs_now_q;
  logic [3:0]  nibble_now_q, nibble_now_d;
  logic [7:0]  value_q;
  logic        valid_q;
  logic        en_q, last_q, rs_q;
  logic [3:0]  nib_q;
  logic [15:0] hold_q;

  logic [7:0]  cur_byte;
  logic [3:0]  hi_nib, lo_nib;
  logic        en_d;
  logic [3:0]  nib_d;
  logic [15:0] hold_d;

  assign cur_byte = cmd_i.is_init ? init_cmd(cmd_i.byte_idx) : value_q;
  assign hi_nib   = cur_byte[7:4];
  assign lo_nib   = cur_byte[3:0];

  always_comb begin
    en_d         = 1'b0;
    nib_d        = lo_nib;
    hold_d       = '0;
    nibble_now_d = nibble_now_q;
    unique case (cmd_i.step)
      STEP_SETUP: begin
        nib_d  = nibble_now_q;
        hold_d = setup_delay_q;
      end
      STEP_HI_EN: begin
        en_d   = 1'b1;
        nib_d  = hi_nib;
        hold_d = enable_high_q;
      end
      STEP_HI_LO: nib_d = hi_nib;
      STEP_LO_EN: begin
        en_d   = 1'b1;
        hold_d = enable_high_q;
      end
      STEP_LO_LO: begin
        hold_d       = cmd_i.is_init ? init_wait(cmd_i.byte_idx) : 16'd0;
        nibble_now_d = lo_nib;
      end
      default: ;
    endcase
  end

  assign out_free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_delay_q <= SETUP_DELAY_RST;
      enable_high_q <= ENABLE_HIGH_RST;
      rs_now_q      <= 1'b0;
      nibble_now_q  <= '0;
      valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SETUP_DELAY: setup_delay_q <= cfg_wdata_i;
          CFG_ENABLE_HIGH: enable_high_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        rs_now_q <= (in_func_i == FUNC_DATA);
      end
      if (cmd_i.emit) begin
        nibble_now_q <= nibble_now_d;
        valid_q      <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_value_i;
    end
    if (cmd_i.emit) begin
      rs_q   <= rs_now_q;
      en_q   <= en_d;
      nib_q  <= nib_d;
      hold_q <= hold_d;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_rs_o     = rs_q;
  assign out_en_o     = en_q;
  assign out_nibble_o = nib_q;
  assign out_hold_o   = hold_q;
  assign out_last_o   = last_q;

endmodule

>>> rtl/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD 4-bit nibble write sequencer.
//
// This block turns one request beat (write a command byte, write a data byte,
// or run the power-up initialization) into a list of pin-state beats for a
// character LCD wired in 4-bit mode. Each output beat gives the register-select
// level, the enable level, the four data pin levels and how many microseconds
// a downstream timer must hold them; tlast marks the final beat of a request.
// A byte write gives five beats: register select with the previous data pins
// held for the setup delay, then the high nibble and the low nibble, each as
// an enable-high beat followed by an enable-low beat. Initialization gives
// nine such bytes (45 beats), with each byte's trailing wait folded into the
// hold of its final beat. The request code 3 is accepted and dropped. Once a
// request is accepted, the controller emits one beat per clock whenever the
// output register is free, and the output side can stall it by holding
// tready low. The next request is taken at the clock edge that follows
// the one that loads the last beat of the current request into the output
// register. The setup delay and enable-high time are written through the
// configuration port (index 0 and 1, both reset to 10000 us); the user is
// to write them only while the block is idle, which the block does not
// enforce.
module char_lcd_nibble_write_sequencer import clcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // Pin-state stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] en_level, [4:1] data_nibble, [20:5] hold_us
  output logic [0:0]  m_axis_tuser,   // [0] rs_level
  output logic        m_axis_tlast
);

  clcd_cmd_t   cmd;
  logic        out_free;
  logic        out_rs;
  logic        out_en;
  logic [3:0]  out_nibble;
  logic [15:0] out_hold;

  clcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  clcd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_func_i    (s_axis_tuser),
    .in_value_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .out_free_o   (out_free),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rs_o     (out_rs),
    .out_en_o     (out_en),
    .out_nibble_o (out_nibble),
    .out_hold_o   (out_hold),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_hold, out_nibble, out_en};
  assign m_axis_tuser = out_rs;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the character LCD 4-bit nibble write sequencer.
module testbench;
  import clcd_pkg::*;

  // The run stops here no matter what. The slowest correct run is about 100
  // requests of 45 beats each with every beat stalled, so this leaves plenty
  // of room.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Cycles to let pass after the last expected beat before touching the
  // registers or ending the run, so a dropped request can leave the block.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RAND_PHASES = 5;
  localparam int unsigned RAND_PER_PHASE = 20;

  // Power-up command bytes and the wait that follows each of them.
  localparam logic [7:0] BOOT_BYTES [9] = '{8'h03, 8'h03, 8'h03, 8'h02, 8'h02,
                                            8'h08, 8'h0C, 8'h01, 8'h06};
  localparam logic [15:0] BOOT_WAITS [9] = '{16'd10000, 16'd200, 16'd10000,
                                             16'd100, 16'd100, 16'd100,
                                             16'd100, 16'd100, 16'd10000};

  // One pin state as the block should present it.
  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        last;
  } pin_beat_t;

  // Directed rows: a request checked against the predictor, a request whose
  // nibbles are typed in, or a register write done while the block is idle.
  typedef enum logic [1:0] {ROW_REQ, ROW_CHK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  fn;
    logic [7:0]  val;
    logic        rs;     // typed register select level
    logic [3:0]  prev;   // typed data pins held during the setup beat
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [15:0] setup;  // register values for a write row
    logic [15:0] enh;
  } row_t;

  localparam int unsigned DIR_N = 19;

  row_t dir_rows [DIR_N] = '{
    // Straight after reset: both holds are 10000 and the pins sit at zero.
    '{ROW_CHK, FUNC_CMD,  8'hFF, 1'b0, 4'h0, 4'hF, 4'hF, 16'd0, 16'd0},
    '{ROW_CHK, FUNC_DATA, 8'h00, 1'b1, 4'hF, 4'h0, 4'h0, 16'd0, 16'd0},
    // The unused code must leave the pin levels alone.
    '{ROW_REQ, FUNC_NONE, 8'hA5, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_CHK, FUNC_DATA, 8'hA5, 1'b1, 4'h0, 4'hA, 4'h5, 16'd0, 16'd0},
    // Initialization ignores its value and ends on command 06.
    '{ROW_REQ, FUNC_INIT, 8'h5A, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_CHK, FUNC_CMD,  8'h3C, 1'b0, 4'h6, 4'h3, 4'hC, 16'd0, 16'd0},
    '{ROW_REQ, FUNC_DATA, 8'h5A, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    // Shortest setup, longest enable.
    '{ROW_CFG, FUNC_CMD,  8'h00, 1'b0, 4'h0, 4'h0, 4'h0, 16'd1, 16'd65535},
    '{ROW_REQ, FUNC_CMD,  8'h81, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_REQ, FUNC_INIT, 8'hFF, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_REQ, FUNC_NONE, 8'h00, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_REQ, FUNC_DATA, 8'h7E, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    // Longest setup, shortest enable.
    '{ROW_CFG, FUNC_CMD,  8'h00, 1'b0, 4'h0, 4'h0, 4'h0, 16'd65535, 16'd1},
    '{ROW_REQ, FUNC_DATA, 8'hC3, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_REQ, FUNC_CMD,  8'h00, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    // Zero holds must come out as zero.
    '{ROW_CFG, FUNC_CMD,  8'h00, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_REQ, FUNC_CMD,  8'h12, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_REQ, FUNC_INIT, 8'h00, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0},
    '{ROW_REQ, FUNC_DATA, 8'hFF, 1'b0, 4'h0, 4'h0, 4'h0, 16'd0, 16'd0}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = CFG_SETUP_DELAY;
  logic [15:0] cfg_wdata_i   = 16'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic [1:0]  s_axis_tuser  = FUNC_CMD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  char_lcd_nibble_write_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] value
    .s_axis_tuser  (s_axis_tuser),   // [1:0] func
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] en_level, [4:1] data_nibble, [20:5] hold_us
    .m_axis_tuser  (m_axis_tuser),   // [0] rs_level
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predictor state: the register copies and the pin levels last driven.
  logic [15:0] setup_us;
  logic [15:0] enh_us;
  logic        lcd_rs_now;
  logic [3:0]  lcd_nib_now;

  // Pin states still owed by the block, oldest first.
  pin_beat_t   pins_due [$];

  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  // Set for the last stretch of the run, where neither side idles.
  bit          calm_run = 1'b0;
  // The sender bumps this to ask the receiver for one long hold-off.
  int unsigned hold_asks = 0;
  int unsigned hold_served = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Queue the five pin states of one byte write: register select settles with
  // the old data pins, then high and low nibble, each enable high then low.
  // The tail wait goes on the final enable-low state.
  task automatic queue_byte(input logic rs, input logic [3:0] prev,
                            input logic [3:0] hi, input logic [3:0] lo,
                            input logic [15:0] tail);
    pins_due.push_back('{rs, 1'b0, prev, setup_us, 1'b0});
    pins_due.push_back('{rs, 1'b1, hi,   enh_us,   1'b0});
    pins_due.push_back('{rs, 1'b0, hi,   16'd0,    1'b0});
    pins_due.push_back('{rs, 1'b1, lo,   enh_us,   1'b0});
    pins_due.push_back('{rs, 1'b0, lo,   tail,     1'b0});
    lcd_rs_now  = rs;
    lcd_nib_now = lo;
  endtask

  // The final pin state of a request carries tlast.
  task automatic mark_last();
    pin_beat_t b;
    b = pins_due.pop_back();
    b.last = 1'b1;
    pins_due.push_back(b);
  endtask

  // Work out every pin state that one accepted request must produce.
  task automatic predict_pins(input logic [1:0] fn, input logic [7:0] val);
    case (fn)
      FUNC_CMD: begin
        queue_byte(1'b0, lcd_nib_now, val[7:4], val[3:0], 16'd0);
        mark_last();
      end
      FUNC_DATA: begin
        queue_byte(1'b1, lcd_nib_now, val[7:4], val[3:0], 16'd0);
        mark_last();
      end
      FUNC_INIT: begin
        for (int k = 0; k < 9; k++) begin
          queue_byte(1'b0, lcd_nib_now, BOOT_BYTES[k][7:4], BOOT_BYTES[k][3:0],
                     BOOT_WAITS[k]);
        end
        mark_last();
      end
      default: ;  // unused code: dropped, nothing owed, pins unchanged
    endcase
  endtask

  // Offer one request beat, possibly after a sender gap, and return at the
  // clock edge where it was taken. Called right after a rising edge.
  task automatic offer_req(input logic [1:0] fn, input logic [7:0] val);
    if (!calm_run && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= val;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering, wait until every owed beat has arrived and then a few
  // more cycles so a dropped request has surely left the block.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers, the setup delay and then the enable-high time, on back-to-back cycles.
  task automatic write_regs(input logic [15:0] setup, input logic [15:0] enh);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SETUP_DELAY;
    cfg_wdata_i <= setup;
    @(posedge clk_i);
    cfg_index_i <= CFG_ENABLE_HIGH;
    cfg_wdata_i <= enh;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    setup_us = setup;
    enh_us   = enh;
  endtask

  // Hold values leaning on the extremes.
  function automatic logic [15:0] pick_hold();
    case ($urandom_range(0, 4))
      0:       return 16'd1;
      1:       return 16'd65535;
      2:       return 16'd0;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly byte writes, some initializations, a few dropped codes.
  function automatic logic [1:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 9)       return FUNC_CMD;
    else if (r < 17) return FUNC_DATA;
    else if (r < 19) return FUNC_INIT;
    else             return FUNC_NONE;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  // Receiver: random stalls, and one long hold-off on request so that the
  // output register fills and the block stops taking requests.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_served) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm_run && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every pin-state beat taken is compared with the oldest owed one.
  always @(posedge clk_i) begin
    pin_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pins_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got tdata %0h tuser %0h tlast %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        err_cnt++;
      end else begin
        want = pins_due.pop_front();
        check_field("rs_level",    32'(want.rs),   32'(m_axis_tuser[0]));
        check_field("en_level",    32'(want.en),   32'(m_axis_tdata[0]));
        check_field("data_nibble", 32'(want.nib),  32'(m_axis_tdata[4:1]));
        check_field("hold_us",     32'(want.hold), 32'(m_axis_tdata[20:5]));
        check_field("tdata pad",   32'd0,          32'(m_axis_tdata[23:21]));
        check_field("last",        32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // Main sequence: reset, the directed table, then random phases, each one
  // opened by a register write while the block is idle.
  initial begin
    row_t r;
    setup_us    = 16'd10000;
    enh_us      = 16'd10000;
    lcd_rs_now  = 1'b0;
    lcd_nib_now = 4'd0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      r = dir_rows[i];
      case (r.kind)
        ROW_CFG: begin
          wait_idle();
          write_regs(r.setup, r.enh);
        end
        ROW_CHK: begin
          // The nibbles of this row are typed in, so only the holds come
          // from the current register values.
          offer_req(r.fn, r.val);
          queue_byte(r.rs, r.prev, r.hi, r.lo, 16'd0);
          mark_last();
        end
        default: begin
          offer_req(r.fn, r.val);
          predict_pins(r.fn, r.val);
        end
      endcase
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      write_regs(pick_hold(), pick_hold());
      // The long hold-off lands in the second phase; the last phase has
      // no idling on either side.
      if (p == 1) hold_asks++;
      if (p == RAND_PHASES - 1) calm_run = 1'b1;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        logic [1:0] fn;
        logic [7:0] val;
        fn  = pick_func();
        val = 8'($urandom_range(0, 255));
        offer_req(fn, val);
        predict_pins(fn, val);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
